// File: rtl/i2c_master_bit_engine_core_macros.svh
// Assertion macros for the I2C master bit engine RTL.
`ifndef I2C_MASTER_BIT_ENGINE_CORE_MACROS_SVH
`define I2C_MASTER_BIT_ENGINE_CORE_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, sampled on clk, quiet during rst
`define I2CM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk, quiet during rst
`define I2CM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define I2CM_ASSERT_IMPL(label, ante, cons)
`define I2CM_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: rtl/i2cm_pkg.sv
// Types and constants of the I2C master bit engine.
`timescale 1ns / 1ps

package i2cm_pkg;

  localparam int unsigned DATA_W = 8;
  localparam int unsigned IN_W   = 16;
  localparam int unsigned OUT_W  = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // Command codes
  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SETUP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd2;

  // Configuration reset values
  localparam logic [7:0] SETUP_RESET   = 8'd4;
  localparam logic [7:0] HALF_RESET    = 8'd2;
  localparam logic [7:0] TIMEOUT_RESET = 8'd250;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_ST_A     = 4'd1,
    PH_ST_B     = 4'd2,
    PH_SP_A     = 4'd3,
    PH_SP_B     = 4'd4,
    PH_WR_LOW   = 4'd5,
    PH_WR_HIGH  = 4'd6,
    PH_WR_TAIL  = 4'd7,
    PH_ACK_REL  = 4'd8,
    PH_ACK_WAIT = 4'd9,
    PH_RD_LOW   = 4'd10,
    PH_RD_HIGH  = 4'd11,
    PH_RA_LOW   = 4'd12,
    PH_RA_HIGH  = 4'd13
  } phase_t;

  typedef struct packed {
    logic [7:0] setup_ticks;
    logic [7:0] half_bit_ticks;
    logic [7:0] ack_timeout;
  } cfg_t;

  // Engine state carried from one tick to the next
  typedef struct packed {
    phase_t      phase;
    logic [3:0]  bit_index;
    logic [7:0]  tick;
    logic [7:0]  wait_cnt;
    logic [7:0]  shift_byte;
    logic        ack_choice;
    logic        scl;
    logic        sda;
    logic        en;
    logic        nack;
    logic [7:0]  rx;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase:      PH_IDLE,
    bit_index:  4'd0,
    tick:       8'd0,
    wait_cnt:   8'd0,
    shift_byte: 8'd0,
    ack_choice: 1'b0,
    scl:        1'b1,
    sda:        1'b1,
    en:         1'b1,
    nack:       1'b0,
    rx:         8'd0
  };

  // One tick item; op sits in the lowest bits
  typedef struct packed {
    logic       sda_in;
    logic       send_ack;
    logic [7:0] tx_byte;
    logic [2:0] op;
  } item_t;

endpackage

// File: rtl/i2cm_step.sv
// Next-state logic of the I2C master bit engine for one tick.
`timescale 1ns / 1ps

module i2cm_step (
  input  i2cm_pkg::state_t st,
  input  i2cm_pkg::cfg_t   cfg,
  input  i2cm_pkg::item_t  item,
  output i2cm_pkg::state_t st_next,
  output logic             done
);
  import i2cm_pkg::*;

  logic [7:0] dur;
  logic [8:0] tick_inc;
  logic       elapsed;
  logic       timed;
  logic [3:0] bit_inc;
  logic [7:0] rd_shift;
  phase_t     phase_next;

  // Pick the hold time of the current phase and test whether it has run out
  always_comb begin
    dur = (st.phase == PH_ST_A || st.phase == PH_ST_B ||
           st.phase == PH_SP_A || st.phase == PH_SP_B) ? cfg.setup_ticks
                                                      : cfg.half_bit_ticks;
  end
  assign tick_inc = {1'b0, st.tick} + 9'd1;
  assign elapsed  = (tick_inc >= {1'b0, dur});
  assign timed    = (st.phase != PH_IDLE) && (st.phase != PH_ACK_WAIT);
  assign bit_inc  = st.bit_index + 4'd1;
  assign rd_shift = {st.shift_byte[6:0], item.sda_in};

  // Next phase
  always_comb begin
    phase_next = st.phase;
    unique case (st.phase)
      PH_IDLE: begin
        unique case (item.op)
          OP_START: phase_next = PH_ST_A;
          OP_STOP:  phase_next = PH_SP_A;
          OP_WRITE: phase_next = PH_WR_LOW;
          OP_READ:  phase_next = PH_RD_LOW;
          default:  phase_next = PH_IDLE;
        endcase
      end
      PH_ST_A:    if (elapsed) phase_next = PH_ST_B;
      PH_ST_B:    if (elapsed) phase_next = PH_IDLE;
      PH_SP_A:    if (elapsed) phase_next = PH_SP_B;
      PH_SP_B:    if (elapsed) phase_next = PH_IDLE;
      PH_WR_LOW:  if (elapsed) phase_next = PH_WR_HIGH;
      PH_WR_HIGH: if (elapsed) phase_next = PH_WR_TAIL;
      PH_WR_TAIL: begin
        if (elapsed) phase_next = (bit_inc < BITS_PER_BYTE) ? PH_WR_LOW : PH_ACK_REL;
      end
      PH_ACK_REL: if (elapsed) phase_next = PH_ACK_WAIT;
      PH_ACK_WAIT: begin
        if (!item.sda_in) begin
          phase_next = PH_IDLE;
        end else if (st.wait_cnt >= cfg.ack_timeout) begin
          phase_next = PH_SP_A;
        end
      end
      PH_RD_LOW:  if (elapsed) phase_next = PH_RD_HIGH;
      PH_RD_HIGH: begin
        if (elapsed) phase_next = (bit_inc < BITS_PER_BYTE) ? PH_RD_LOW : PH_RA_LOW;
      end
      PH_RA_LOW:  if (elapsed) phase_next = PH_RA_HIGH;
      PH_RA_HIGH: if (elapsed) phase_next = PH_IDLE;
      default:    phase_next = PH_IDLE;
    endcase
  end

  // Datapath: pins, counters, shift register and flags
  always_comb begin
    st_next       = st;
    st_next.phase = phase_next;
    st_next.tick  = (timed && !elapsed) ? tick_inc[7:0] : 8'd0;
    done          = 1'b0;
    unique case (st.phase)
      PH_IDLE: begin
        unique case (item.op)
          OP_START: begin
            st_next.bit_index = 4'd0;
            st_next.scl = 1'b1;
            st_next.sda = 1'b1;
            st_next.en  = 1'b1;
          end
          OP_STOP: begin
            st_next.bit_index = 4'd0;
            st_next.scl = 1'b1;
            st_next.sda = 1'b0;
            st_next.en  = 1'b1;
          end
          OP_WRITE: begin
            st_next.bit_index  = 4'd0;
            st_next.scl        = 1'b0;
            st_next.en         = 1'b1;
            st_next.sda        = item.tx_byte[7];
            st_next.shift_byte = {item.tx_byte[6:0], 1'b0};
          end
          OP_READ: begin
            st_next.bit_index  = 4'd0;
            st_next.ack_choice = item.send_ack;
            st_next.shift_byte = 8'd0;
            st_next.scl        = 1'b0;
            st_next.en         = 1'b0;
            st_next.sda        = 1'b1;
          end
          default: ;
        endcase
      end
      PH_ST_A: if (elapsed) st_next.sda = 1'b0;
      PH_ST_B: begin
        if (elapsed) begin
          st_next.scl = 1'b0;
          done = 1'b1;
        end
      end
      PH_SP_A: if (elapsed) st_next.sda = 1'b1;
      PH_SP_B: if (elapsed) done = 1'b1;
      PH_WR_LOW:  if (elapsed) st_next.scl = 1'b1;
      PH_WR_HIGH: if (elapsed) st_next.scl = 1'b0;
      PH_WR_TAIL: begin
        if (elapsed) begin
          st_next.bit_index = bit_inc;
          st_next.scl       = 1'b0;
          if (bit_inc < BITS_PER_BYTE) begin
            // put the next data bit on SDA
            st_next.en         = 1'b1;
            st_next.sda        = st.shift_byte[7];
            st_next.shift_byte = {st.shift_byte[6:0], 1'b0};
          end else begin
            // release SDA for the slave ACK
            st_next.en  = 1'b0;
            st_next.sda = 1'b1;
          end
        end
      end
      PH_ACK_REL: begin
        if (elapsed) begin
          st_next.scl      = 1'b1;
          st_next.wait_cnt = 8'd0;
        end
      end
      PH_ACK_WAIT: begin
        if (!item.sda_in) begin
          st_next.scl  = 1'b0;
          st_next.nack = 1'b0;
          done = 1'b1;
        end else if (st.wait_cnt >= cfg.ack_timeout) begin
          // give up and issue a stop
          st_next.nack = 1'b1;
          st_next.sda  = 1'b0;
          st_next.scl  = 1'b1;
          st_next.en   = 1'b1;
        end else begin
          st_next.wait_cnt = st.wait_cnt + 8'd1;
        end
      end
      PH_RD_LOW: if (elapsed) st_next.scl = 1'b1;
      PH_RD_HIGH: begin
        if (elapsed) begin
          st_next.shift_byte = rd_shift;
          st_next.bit_index  = bit_inc;
          st_next.scl        = 1'b0;
          if (!(bit_inc < BITS_PER_BYTE)) begin
            // latch the byte and drive ACK or NACK
            st_next.rx  = rd_shift;
            st_next.en  = 1'b1;
            st_next.sda = ~st.ack_choice;
          end
        end
      end
      PH_RA_LOW: if (elapsed) st_next.scl = 1'b1;
      PH_RA_HIGH: begin
        if (elapsed) begin
          st_next.scl = 1'b0;
          done = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/i2c_master_bit_engine_core.sv
// Top level of the I2C master bit engine: state, configuration and result register.
`timescale 1ns / 1ps
`include "i2c_master_bit_engine_core_macros.svh"

// Usage:
//   Each item on the s_ channel is one bus tick: a command code (taken only
//   while idle), the byte to write, the ACK choice for a read and the sampled
//   SDA level. Each accepted item yields exactly one item on the m_ channel
//   with the pin levels, SDA enable, busy, a done pulse, the last received
//   byte and the missing-ACK flag, all as they stand after that tick.
//   Edge timing is set through the cfg_ port: 0 setup ticks, 1 half-bit
//   ticks, 2 ACK timeout. Write it only while the engine is idle.
//   An accepted item's result is registered and shown in the next cycle; one
//   item is taken per cycle, set by the single state update of the bit sequencer.
//   When the receiver stalls, the result is held in the output register and
//   s_tready drops until it is taken; no tick is lost or repeated.
//   Reset (rst, synchronous) returns the engine to idle with SCL and SDA high
//   and driven, loads the default timing and empties the output register.
module i2c_master_bit_engine_core (
  input  logic                            clk,
  input  logic                            rst,
  // op[2:0], tx_byte[10:3], send_ack[11], sda_in[12], zero fill above
  input  logic [i2cm_pkg::IN_W-1:0]       s_tdata,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // scl_level[0], sda_level[1], sda_enable[2], busy_res[3], done_res[4],
  // rx_byte[12:5], ack_missing[13], zero fill above
  output logic [i2cm_pkg::OUT_W-1:0]      m_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic                            cfg_we,
  input  logic [i2cm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [i2cm_pkg::DATA_W-1:0]     cfg_data
);
  import i2cm_pkg::*;

  state_t st;
  state_t st_next;
  cfg_t   cfg;
  item_t  item;
  logic   done;
  logic   accept;

  assign item     = s_tdata[$bits(item_t)-1:0];
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  i2cm_step u_step (
    .st      (st),
    .cfg     (cfg),
    .item    (item),
    .st_next (st_next),
    .done    (done)
  );

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.setup_ticks    <= SETUP_RESET;
      cfg.half_bit_ticks <= HALF_RESET;
      cfg.ack_timeout    <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SETUP:   cfg.setup_ticks    <= cfg_data;
        REG_HALF:    cfg.half_bit_ticks <= cfg_data;
        REG_TIMEOUT: cfg.ack_timeout    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance the engine state on each accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_RESET;
    end else if (accept) begin
      st <= st_next;
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {2'b00, st_next.nack, st_next.rx, done,
                  (st_next.phase != PH_IDLE), st_next.en, st_next.sda, st_next.scl};
    end
  end

  `I2CM_ASSERT_IMPL(a_done_not_busy, m_tvalid && m_tdata[4], !m_tdata[3])
  `I2CM_ASSERT_NEXT(a_accept_gives_result, accept, m_tvalid)
  `I2CM_ASSERT_IMPL(a_ack_wait_pins, st.phase == PH_ACK_WAIT, st.scl && !st.en)
  `I2CM_ASSERT_IMPL(a_read_released, st.phase == PH_RD_LOW || st.phase == PH_RD_HIGH, !st.en)
  `I2CM_ASSERT_IMPL(a_idle_tick_clear, st.phase == PH_IDLE, st.tick == 8'd0)

endmodule

// File: bench/i2c_master_bit_engine_core_checker.sv
// Result checker for the I2C master bit engine: tracks every tick and compares each result.
`timescale 1ns / 1ps

module i2c_master_bit_engine_core_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [i2cm_pkg::IN_W-1:0]      s_tdata,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [i2cm_pkg::OUT_W-1:0]     m_tdata,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic                           cfg_we,
  input  logic [i2cm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [i2cm_pkg::DATA_W-1:0]    cfg_data,
  output int                             fail_count,
  output int                             pending,
  output int                             cmds_done,
  output int                             ack_timeouts,
  output int                             results_checked,
  output logic                           engine_busy
);
  import i2cm_pkg::*;

  // One result item, scl_lvl in the lowest bit
  typedef struct packed {
    logic       ack_missing;
    logic [7:0] rx_byte;
    logic       done;
    logic       busy;
    logic       sda_en;
    logic       sda_lvl;
    logic       scl_lvl;
  } pins_t;

  // Timing registers as the engine sees them
  logic [7:0] setup_cfg;
  logic [7:0] half_cfg;
  logic [7:0] timeout_cfg;

  // Bus engine state
  phase_t     eng_phase;
  logic [3:0] bit_cnt;
  logic [7:0] hold_cnt;
  logic [7:0] ack_wait_cnt;
  logic [7:0] shift_reg;
  logic       ack_level_sel;
  logic       scl_q;
  logic       sda_q;
  logic       en_q;
  logic       nack_q;
  logic [7:0] rx_q;

  pins_t pin_results_q[$];
  int    n_fail;
  int    n_done;
  int    n_tmo;
  int    n_checked;

  function automatic void go(phase_t ph);
    eng_phase = ph;
    hold_cnt  = '0;
  endfunction

  // Count one tick of a hold; a hold of zero ends like a hold of one
  function automatic logic hold_over(logic [7:0] dur);
    logic [8:0] next_cnt;
    next_cnt = {1'b0, hold_cnt} + 9'd1;
    if (next_cnt >= {1'b0, dur}) begin
      hold_cnt = '0;
      return 1'b1;
    end
    hold_cnt = next_cnt[7:0];
    return 1'b0;
  endfunction

  // Put the next data bit on SDA with SCL low, MSB first
  function automatic void drive_bit();
    scl_q     = 1'b0;
    en_q      = 1'b1;
    sda_q     = shift_reg[7];
    shift_reg = {shift_reg[6:0], 1'b0};
    go(PH_WR_LOW);
  endfunction

  function automatic void begin_stop();
    sda_q = 1'b0;
    scl_q = 1'b1;
    en_q  = 1'b1;
    go(PH_SP_A);
  endfunction

  // Advance the engine by one tick and form the result it shows
  task automatic step_engine(input item_t it, output pins_t res);
    logic finished;
    finished = 1'b0;
    case (eng_phase)
      PH_IDLE: begin
        case (it.op)
          OP_START: begin
            bit_cnt = '0;
            scl_q   = 1'b1;
            sda_q   = 1'b1;
            en_q    = 1'b1;
            go(PH_ST_A);
          end
          OP_STOP: begin
            bit_cnt = '0;
            begin_stop();
          end
          OP_WRITE: begin
            bit_cnt   = '0;
            shift_reg = it.tx_byte;
            drive_bit();
          end
          OP_READ: begin
            bit_cnt       = '0;
            ack_level_sel = it.send_ack;
            shift_reg     = '0;
            scl_q         = 1'b0;
            en_q          = 1'b0;
            sda_q         = 1'b1;
            go(PH_RD_LOW);
          end
          default: ;
        endcase
      end
      PH_ST_A: if (hold_over(setup_cfg)) begin
        sda_q = 1'b0;
        go(PH_ST_B);
      end
      PH_ST_B: if (hold_over(setup_cfg)) begin
        scl_q = 1'b0;
        go(PH_IDLE);
        finished = 1'b1;
      end
      PH_SP_A: if (hold_over(setup_cfg)) begin
        sda_q = 1'b1;
        go(PH_SP_B);
      end
      PH_SP_B: if (hold_over(setup_cfg)) begin
        go(PH_IDLE);
        finished = 1'b1;
      end
      PH_WR_LOW: if (hold_over(half_cfg)) begin
        scl_q = 1'b1;
        go(PH_WR_HIGH);
      end
      PH_WR_HIGH: if (hold_over(half_cfg)) begin
        scl_q = 1'b0;
        go(PH_WR_TAIL);
      end
      PH_WR_TAIL: if (hold_over(half_cfg)) begin
        bit_cnt = bit_cnt + 4'd1;
        if (bit_cnt < BITS_PER_BYTE) begin
          drive_bit();
        end else begin
          en_q  = 1'b0;
          sda_q = 1'b1;
          scl_q = 1'b0;
          go(PH_ACK_REL);
        end
      end
      PH_ACK_REL: if (hold_over(half_cfg)) begin
        scl_q        = 1'b1;
        ack_wait_cnt = '0;
        go(PH_ACK_WAIT);
      end
      // Poll for ACK; give up with a stop once the timeout is used up
      PH_ACK_WAIT: begin
        if (!it.sda_in) begin
          scl_q  = 1'b0;
          nack_q = 1'b0;
          go(PH_IDLE);
          finished = 1'b1;
        end else if (ack_wait_cnt >= timeout_cfg) begin
          nack_q = 1'b1;
          begin_stop();
          n_tmo++;
        end else begin
          ack_wait_cnt = ack_wait_cnt + 8'd1;
        end
      end
      PH_RD_LOW: if (hold_over(half_cfg)) begin
        scl_q = 1'b1;
        go(PH_RD_HIGH);
      end
      // Sample SDA at the end of the high half
      PH_RD_HIGH: if (hold_over(half_cfg)) begin
        shift_reg = {shift_reg[6:0], it.sda_in};
        bit_cnt   = bit_cnt + 4'd1;
        scl_q     = 1'b0;
        if (bit_cnt < BITS_PER_BYTE) begin
          go(PH_RD_LOW);
        end else begin
          rx_q  = shift_reg;
          en_q  = 1'b1;
          sda_q = ~ack_level_sel;
          go(PH_RA_LOW);
        end
      end
      PH_RA_LOW: if (hold_over(half_cfg)) begin
        scl_q = 1'b1;
        go(PH_RA_HIGH);
      end
      PH_RA_HIGH: if (hold_over(half_cfg)) begin
        scl_q = 1'b0;
        go(PH_IDLE);
        finished = 1'b1;
      end
      default: go(PH_IDLE);
    endcase
    res = '{ack_missing: nack_q, rx_byte: rx_q, done: finished,
            busy: (eng_phase != PH_IDLE), sda_en: en_q, sda_lvl: sda_q, scl_lvl: scl_q};
  endtask

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_fail++;
    end
  endtask

  // Track config writes and items, compare results in order
  always @(posedge clk) begin
    item_t it;
    pins_t want;
    pins_t got;
    if (rst) begin
      setup_cfg     = SETUP_RESET;
      half_cfg      = HALF_RESET;
      timeout_cfg   = TIMEOUT_RESET;
      eng_phase     = PH_IDLE;
      bit_cnt       = '0;
      hold_cnt      = '0;
      ack_wait_cnt  = '0;
      shift_reg     = '0;
      ack_level_sel = 1'b0;
      scl_q         = 1'b1;
      sda_q         = 1'b1;
      en_q          = 1'b1;
      nack_q        = 1'b0;
      rx_q          = '0;
      pin_results_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SETUP:   setup_cfg   = cfg_data;
          REG_HALF:    half_cfg    = cfg_data;
          REG_TIMEOUT: timeout_cfg = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        it = s_tdata[$bits(item_t)-1:0];
        step_engine(it, want);
        pin_results_q.push_back(want);
        if (want.done) n_done++;
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata[$bits(pins_t)-1:0];
        if (pin_results_q.size() == 0) begin
          $error("result %0h arrived with no tick waiting for it", got);
          n_fail++;
        end else begin
          want = pin_results_q.pop_front();
          check_field("scl_level", want.scl_lvl, got.scl_lvl);
          check_field("sda_level", want.sda_lvl, got.sda_lvl);
          check_field("sda_enable", want.sda_en, got.sda_en);
          check_field("busy_res", want.busy, got.busy);
          check_field("done_res", want.done, got.done);
          check_field("rx_byte", want.rx_byte, got.rx_byte);
          check_field("ack_missing", want.ack_missing, got.ack_missing);
        end
        n_checked++;
      end
    end
    fail_count      <= n_fail;
    pending         <= pin_results_q.size();
    cmds_done       <= n_done;
    ack_timeouts    <= n_tmo;
    results_checked <= n_checked;
    engine_busy     <= (eng_phase != PH_IDLE);
  end

endmodule

// File: bench/i2c_master_bit_engine_core_tb.sv
// Testbench top for the I2C master bit engine: clock, reset, tick stimulus and verdict.
`timescale 1ns / 1ps

module i2c_master_bit_engine_core_tb;
  import i2cm_pkg::*;

  localparam int     CLK_PERIOD = 10;
  localparam longint LIMIT_NS   = 2_000_000;

  // Command codes the engine does not know
  localparam logic [2:0] OP_SPARE_5 = 3'd5;
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  // Timing settings; the first one matches the reset values
  localparam int N_SETS = 9;
  localparam logic [7:0] SET_SETUP [N_SETS] = '{8'd4, 8'd1, 8'd0, 8'd2, 8'd1, 8'd6,
                                                8'd16, 8'd6, 8'd3};
  localparam logic [7:0] SET_HALF  [N_SETS] = '{8'd2, 8'd1, 8'd0, 8'd3, 8'd1, 8'd1,
                                                8'd1, 8'd4, 8'd2};
  localparam logic [7:0] SET_TMO   [N_SETS] = '{8'd250, 8'd1, 8'd0, 8'd6, 8'd255, 8'd0,
                                                8'd3, 8'd20, 8'd12};
  localparam int         SET_TRANS [N_SETS] = '{1, 2, 2, 1, 1, 1, 1, 1, 1};

  typedef enum int {SDA_RANDOM, SDA_LOW, SDA_HIGH, SDA_MOSTLY_HIGH, SDA_TOGGLE} sda_mode_t;
  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SPARSE, RX_BLOCKED} rx_mode_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic [IN_W-1:0]      s_tdata   = '0;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [OUT_W-1:0]     m_tdata;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_SETUP;
  logic [DATA_W-1:0]    cfg_data  = '0;

  int   fail_count;
  int   pending;
  int   cmds_done;
  int   ack_timeouts;
  int   results_checked;
  logic engine_busy;

  int       burst_left = 0;
  int       ticks_sent = 0;
  int       n_drains   = 0;
  logic     toggle_sda = 1'b0;
  rx_mode_t rx_mode    = RX_FREE;
  logic [6:0] rx_slot  = '0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  i2c_master_bit_engine_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  i2c_master_bit_engine_core_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tdata         (s_tdata),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .m_tdata         (m_tdata),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending         (pending),
    .cmds_done       (cmds_done),
    .ack_timeouts    (ack_timeouts),
    .results_checked (results_checked),
    .engine_busy     (engine_busy)
  );

  // Receiver: switch stall pattern each time the 7-bit slot counter wraps
  always @(posedge clk) begin
    rx_slot <= rx_slot + 7'd1;
    if (rx_slot == '0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_FREE:   m_tready <= 1'b1;
      RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: m_tready <= (rx_slot[1:0] == 2'd0);
      default:   m_tready <= (rx_slot[4:3] != 2'd0);
    endcase
  end

  function automatic logic [IN_W-1:0] pack_tick(item_t it);
    logic [IN_W-1:0] w;
    w = '0;
    w[$bits(item_t)-1:0] = it;
    return w;
  endfunction

  function automatic logic next_sda(sda_mode_t mode);
    case (mode)
      SDA_LOW:         return 1'b0;
      SDA_HIGH:        return 1'b1;
      SDA_MOSTLY_HIGH: return ($urandom_range(0, 15) != 0);
      SDA_TOGGLE: begin
        toggle_sda = ~toggle_sda;
        return toggle_sda;
      end
      default:         return 1'($urandom_range(0, 1));
    endcase
  endfunction

  function automatic sda_mode_t pick_sda_mode();
    case ($urandom_range(0, 6))
      0:       return SDA_LOW;
      1:       return SDA_HIGH;
      2:       return SDA_MOSTLY_HIGH;
      3:       return SDA_TOGGLE;
      default: return SDA_RANDOM;
    endcase
  endfunction

  // Offer one tick; between bursts idle for a while or drain completely
  task automatic send_tick(logic [2:0] op, logic [7:0] tx, logic ack, logic sda);
    item_t it;
    int    gap;
    it = '{sda_in: sda, send_ack: ack, tx_byte: tx, op: op};
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = $urandom_range(0, 4);
      if ($urandom_range(0, 39) == 0) begin
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        n_drains++;
      end else if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pack_tick(it);
    do @(posedge clk); while (!s_tready);
    burst_left--;
    ticks_sent++;
  endtask

  // Issue a command; for a known code keep ticking until a command finishes
  task automatic run_command(logic [2:0] op, logic [7:0] tx, logic ack, sda_mode_t mode,
                             logic noisy);
    int         done_mark;
    logic [2:0] fill_op;
    done_mark = cmds_done;
    send_tick(op, tx, ack, next_sda(mode));
    if (op inside {OP_START, OP_STOP, OP_WRITE, OP_READ}) begin
      while (cmds_done <= done_mark) begin
        fill_op = (noisy && $urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : OP_NONE;
        send_tick(fill_op, 8'($urandom), 1'($urandom), next_sda(mode));
      end
    end
  endtask

  task automatic run_random_command(logic [2:0] op);
    run_command(op, 8'($urandom), 1'($urandom), pick_sda_mode(), ($urandom_range(0, 3) == 0));
  endtask

  // Start, one to three data bytes, stop; now and then a stray code
  task automatic run_transaction();
    repeat ($urandom_range(0, 2)) send_tick(OP_NONE, 8'($urandom), 1'($urandom), 1'($urandom));
    run_random_command(OP_START);
    repeat ($urandom_range(1, 3)) begin
      if ($urandom_range(0, 7) == 0) run_random_command(3'($urandom_range(0, 7)));
      else if ($urandom_range(0, 1) == 0) run_random_command(OP_WRITE);
      else run_random_command(OP_READ);
    end
    run_random_command(OP_STOP);
  endtask

  // Tick until idle, stop sending and let every result come back
  task automatic settle_engine();
    do send_tick(OP_NONE, 8'($urandom), 1'($urandom), 1'($urandom)); while (engine_busy);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // Stimulus and verdict
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Idle and unknown codes, with the data bits both clear and set
    send_tick(OP_NONE, 8'h00, 1'b0, 1'b0);
    send_tick(OP_SPARE_5, 8'hFF, 1'b1, 1'b1);
    send_tick(OP_SPARE_6, 8'hFF, 1'b1, 1'b0);
    send_tick(OP_SPARE_7, 8'h00, 1'b0, 1'b1);
    // Every command at reset timing: quick ACK with commands thrown in while busy,
    // ACK timeout with automatic stop, ACK and NACK reads, late ACK
    run_command(OP_START, 8'h00, 1'b0, SDA_HIGH, 1'b0);
    run_command(OP_WRITE, 8'hFF, 1'b0, SDA_LOW, 1'b1);
    run_command(OP_WRITE, 8'h00, 1'b1, SDA_HIGH, 1'b0);
    run_command(OP_START, 8'h00, 1'b0, SDA_LOW, 1'b0);
    run_command(OP_READ, 8'h00, 1'b1, SDA_LOW, 1'b0);
    run_command(OP_READ, 8'hFF, 1'b0, SDA_HIGH, 1'b0);
    run_command(OP_READ, 8'hA5, 1'b1, SDA_TOGGLE, 1'b0);
    run_command(OP_WRITE, 8'h5A, 1'b0, SDA_MOSTLY_HIGH, 1'b0);
    run_command(OP_STOP, 8'h00, 1'b0, SDA_RANDOM, 1'b0);

    // Random transactions under each timing setting
    for (int s = 0; s < N_SETS; s++) begin
      if (s > 0) begin
        settle_engine();
        write_reg(REG_SETUP, SET_SETUP[s]);
        write_reg(REG_HALF, SET_HALF[s]);
        write_reg(REG_TIMEOUT, SET_TMO[s]);
      end
      repeat (SET_TRANS[s]) run_transaction();
    end

    settle_engine();
    repeat (8) @(posedge clk);
    if (pending != 0) $error("%0d results never arrived", pending);
    $display("Summary: %0d ticks over %0d timing settings, %0d commands finished, %0d ACK timeouts",
             ticks_sent, N_SETS, cmds_done, ack_timeouts);
    $display("Summary: %0d results compared, %0d full drains of the result path",
             results_checked, n_drains);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin
    #(LIMIT_NS);
    $display("Run limit reached before the end of stimulus");
    $display("*** FAILED ***");
    $finish;
  end

endmodule
